[rtl/core/assert_macros.svh]
// Assertion macros used by the top level of the sorted merge block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define KSM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define KSM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ksm_pkg.sv]
// Package with item types, status codes and control structs of the sorted merge block.
`default_nettype none

package ksm_pkg;

    localparam int NUM_LISTS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int DATA_W   = 32;
    localparam int LIST_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_PULL   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_VALUE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic                     command;
        logic [LIST_W-1:0]        list_index;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] out_value;
        logic [LIST_W-1:0]        out_list;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic do_append;
        logic scan_issue;
        logic do_pop;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_pull;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/ksm_ctrl.sv]
// Controller state machine that sequences appends, head scans, pops and result delivery.
`default_nettype none

module ksm_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire ksm_pkg::dp_stat_t  stat,
    output ksm_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_APPEND  = 6'b000010,
        S_SCAN    = 6'b000100,
        S_DRAIN   = 6'b001000,
        S_POP     = 6'b010000,
        S_DELIVER = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready     = 1'b1;
                cmd.load_item = req_valid;
                if (req_valid)
                begin
                    state_next = stat.in_is_pull ? S_SCAN : S_APPEND;
                end
            end
            S_APPEND:
            begin
                cmd.do_append = 1'b1;
                state_next    = S_DELIVER;
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_POP;
            end
            S_POP:
            begin
                cmd.do_pop = 1'b1;
                state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                cmd.load_out = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/ksm_datapath.sv]
// Datapath with the element memory, queue pointers, minimum search and output register.
`default_nettype none

module ksm_datapath
#(
    parameter int NUM_LISTS   = ksm_pkg::NUM_LISTS_DEF,
    parameter int QUEUE_DEPTH = ksm_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ksm_pkg::in_item_t  req,
    input  wire ksm_pkg::ctrl_cmd_t cmd,
    output ksm_pkg::dp_stat_t       stat,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output ksm_pkg::out_item_t      rsp
);

    localparam int LW          = $clog2(NUM_LISTS);
    localparam int POS_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = POS_W + 1;
    localparam int STORE_DEPTH = NUM_LISTS * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DATA_W      = ksm_pkg::DATA_W;
    localparam int LIST_W      = ksm_pkg::LIST_W;

    ksm_pkg::in_item_t         item_reg;
    logic [POS_W-1:0]          rd_pos_reg [NUM_LISTS];
    logic [CNT_W-1:0]          cnt_reg    [NUM_LISTS];
    logic signed [DATA_W-1:0]  store_mem  [STORE_DEPTH];
    logic signed [DATA_W-1:0]  rd_data_reg;

    logic [LW-1:0]             scan_idx_reg;
    logic                      cmp_valid_reg;
    logic                      found_reg;
    logic signed [DATA_W-1:0]  best_val_reg;
    logic [LW-1:0]             best_list_reg;

    ksm_pkg::out_item_t        res_reg;
    ksm_pkg::out_item_t        res_next;
    logic                      rsp_valid_reg;
    ksm_pkg::out_item_t        rsp_reg;

    logic [LW-1:0]             sel_idx;
    logic [POS_W-1:0]          pos_sel;
    logic [CNT_W-1:0]          cnt_sel;
    logic [SUM_W-1:0]          slot_sum;
    logic [POS_W-1:0]          tail_slot;
    logic [POS_W-1:0]          pos_inc;
    logic [ADDR_W-1:0]         list_base;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         wr_addr;
    logic                      in_range;
    logic                      is_full;
    logic                      append_ok;
    logic                      take_head;

    always_comb
    begin
        priority if (cmd.scan_issue)
        begin
            sel_idx = scan_idx_reg;
        end
        else if (cmd.do_pop)
        begin
            sel_idx = best_list_reg;
        end
        else
        begin
            sel_idx = LW'(item_reg.list_index);
        end
    end

    assign pos_sel   = rd_pos_reg[sel_idx];
    assign cnt_sel   = cnt_reg[sel_idx];
    assign slot_sum  = SUM_W'(pos_sel) + SUM_W'(cnt_sel);
    assign tail_slot = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ? POS_W'(slot_sum - SUM_W'(QUEUE_DEPTH))
                                                         : POS_W'(slot_sum);
    assign pos_inc   = (pos_sel == POS_W'(QUEUE_DEPTH - 1)) ? '0 : pos_sel + 1'b1;
    assign list_base = ADDR_W'(sel_idx) * ADDR_W'(QUEUE_DEPTH);
    assign rd_addr   = list_base + ADDR_W'(pos_sel);
    assign wr_addr   = list_base + ADDR_W'(tail_slot);

    assign in_range  = (32'(item_reg.list_index) < NUM_LISTS);
    assign is_full   = (cnt_sel == CNT_W'(QUEUE_DEPTH));
    assign append_ok = in_range && !is_full;
    assign take_head = cmp_valid_reg && (!found_reg || (rd_data_reg < best_val_reg));

    assign stat.in_is_pull = (req.command == ksm_pkg::CMD_PULL);
    assign stat.scan_done  = (scan_idx_reg == LW'(NUM_LISTS - 1));
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        res_next = res_reg;
        if (cmd.do_append)
        begin
            res_next.status    = append_ok ? ksm_pkg::ST_APPENDED : ksm_pkg::ST_FULL;
            res_next.out_value = '0;
            res_next.out_list  = '0;
        end
        else if (cmd.do_pop)
        begin
            if (found_reg)
            begin
                res_next.status    = ksm_pkg::ST_VALUE;
                res_next.out_value = best_val_reg;
                res_next.out_list  = LIST_W'(best_list_reg);
            end
            else
            begin
                res_next.status    = ksm_pkg::ST_EMPTY;
                res_next.out_value = '0;
                res_next.out_list  = '0;
            end
        end
    end

    // Element memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.do_append && append_ok)
        begin
            store_mem[wr_addr] <= item_reg.value;
        end
        if (cmd.scan_issue)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                rd_pos_reg[i] <= '0;
                cnt_reg[i]    <= '0;
            end
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_append && append_ok)
            begin
                cnt_reg[sel_idx] <= cnt_sel + 1'b1;
            end
            if (cmd.do_pop && found_reg)
            begin
                rd_pos_reg[sel_idx] <= pos_inc;
                cnt_reg[sel_idx]    <= cnt_sel - 1'b1;
            end

            if (cmd.load_item)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end

            cmp_valid_reg <= cmd.scan_issue && (cnt_sel != '0);

            if (cmd.load_item)
            begin
                found_reg <= 1'b0;
            end
            else if (take_head)
            begin
                found_reg <= 1'b1;
            end

            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    logic [LW-1:0] cmp_idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req;
        end
        if (cmd.scan_issue)
        begin
            cmp_idx_reg <= scan_idx_reg;
        end
        if (take_head)
        begin
            best_val_reg  <= rd_data_reg;
            best_list_reg <= cmp_idx_reg;
        end
        res_reg <= res_next;
        if (cmd.load_out)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[rtl/core/k_way_sorted_merge.sv]
// Top level of the k-way sorted merge block: controller, datapath and checks.
//
// This block merges up to NUM_LISTS ascending lists into one ascending stream. Each
// list has a circular queue of QUEUE_DEPTH signed 32-bit entries held in one element
// memory. An append item writes its value at the tail of the queue named by
// list_index and answers status 0, or status 1 when that queue is full or the index
// names no list. A pull item removes the smallest head among the non-empty queues
// and answers status 2 with the value and its list; equal heads leave the lowest
// list first. A pull with every queue empty answers status 3. Every item gives
// exactly one result item. The block works on one item at a time. A pull reads the
// heads one list a cycle through the single read port of the element memory and
// compares each against the running minimum. A new item can be accepted while the
// previous result still waits in the output register. No clearing pass is needed
// after reset: the queue pointers and fill counts reset at once, and only written
// entries are ever compared.
`default_nettype none

`include "assert_macros.svh"

module k_way_sorted_merge
#(
    parameter int NUM_LISTS   = ksm_pkg::NUM_LISTS_DEF,
    parameter int QUEUE_DEPTH = ksm_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire ksm_pkg::in_item_t  req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output ksm_pkg::out_item_t      rsp
);

    ksm_pkg::ctrl_cmd_t cmd;
    ksm_pkg::dp_stat_t  stat;

    // The controller owns sequencing; the datapath owns all storage and arithmetic.
    ksm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ksm_datapath
    #(
        .NUM_LISTS   (NUM_LISTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // A result may only be loaded when the output register is empty or being drained.
    `KSM_ASSERT_IMP(a_load_needs_room, cmd.load_out, stat.out_free, "result overwrote a pending item")

    // Memory write, head scan, pop and delivery are separate phases of one item.
    `KSM_ASSERT_IMP(a_one_phase, 1'b1, $onehot0({cmd.do_append, cmd.scan_issue, cmd.do_pop, cmd.load_out}), "overlapping datapath commands")

    // Once an item is taken, no further item is taken until its result is delivered.
    `KSM_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "item accepted while busy")

    // Delivering a result returns the block to accepting items.
    `KSM_ASSERT_NXT(a_idle_after_deliver, cmd.load_out, req_ready && rsp_valid, "block did not return to idle")

endmodule

`default_nettype wire
